@@ hdl/mprf_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// mprf_pkg
// Shared types and codes for the mesh packet relay filter.
// ---------------------------------------------------------------------------
package mprf_pkg;

  // Verdict codes carried on every result word
  localparam logic [2:0] VERD_PENDING   = 3'd0;
  localparam logic [2:0] VERD_RELAY     = 3'd1;
  localparam logic [2:0] VERD_HOP_LIMIT = 3'd2;
  localparam logic [2:0] VERD_SEEN      = 3'd3;
  localparam logic [2:0] VERD_MALFORMED = 3'd4;

  // Configuration port geometry: 64-bit registers at 8-byte spacing
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 64;

  // Register select, taken from paddr[3]
  localparam logic REG_OWN_ID    = 1'b0;
  localparam logic REG_HOP_LIMIT = 1'b1;

  localparam logic [63:0] OWN_ID_RESET    = 64'd0;
  localparam logic [4:0]  HOP_LIMIT_RESET = 5'd6;

  // One result word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_appended;
    logic       end_of_run;
    logic [2:0] verdict;
    logic [7:0] topic_seen;
  } mprf_res_t;

endpackage : mprf_pkg
`default_nettype wire

@@ hdl/mprf_if.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// mprf_if
// Valid/ready channels for packet bytes in and result words out.
// ---------------------------------------------------------------------------
interface mprf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface : mprf_in_if

interface mprf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_appended;
  logic       end_of_run;
  logic [2:0] verdict;
  logic [7:0] topic_seen;

  modport source (output valid, output out_byte, output is_appended, output end_of_run,
                  output verdict, output topic_seen, input ready);
  modport sink   (input valid, input out_byte, input is_appended, input end_of_run,
                  input verdict, input topic_seen, output ready);
endinterface : mprf_out_if
`default_nettype wire

@@ hdl/mprf_cfg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// mprf_cfg
// APB register file: own id and hop limit.
// ---------------------------------------------------------------------------
module mprf_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [mprf_pkg::CFG_AW-1:0] paddr,
  input  wire logic [mprf_pkg::CFG_DW-1:0] pwdata,
  output logic      [mprf_pkg::CFG_DW-1:0] prdata,
  output logic                            pready,
  output logic      [63:0]                own_id,
  output logic      [4:0]                 hop_limit
);
  import mprf_pkg::*;

  logic [63:0] own_id_r;
  logic [4:0]  hop_limit_r;
  logic        wr_en;
  logic        reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r    <= OWN_ID_RESET;
      hop_limit_r <= HOP_LIMIT_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_OWN_ID:    own_id_r    <= pwdata;
        REG_HOP_LIMIT: hop_limit_r <= pwdata[4:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_OWN_ID:    prdata = own_id_r;
      REG_HOP_LIMIT: prdata = {59'd0, hop_limit_r};
      default:       prdata = '0;
    endcase
  end

  assign own_id    = own_id_r;
  assign hop_limit = hop_limit_r;

endmodule : mprf_cfg
`default_nettype wire

@@ hdl/mprf_parse.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// mprf_parse
// Per-byte header capture, path entry compare, hop count and verdict.
// ---------------------------------------------------------------------------
module mprf_parse #(
  parameter int ID_BYTES         = 8,
  parameter int MSG_ID_BYTES     = 4,
  parameter int MAX_PACKET_BYTES = 255
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_fire,
  input  wire logic [7:0]        data_byte,
  input  wire logic              last_byte,
  input  wire logic [63:0]       own_id,
  input  wire logic [4:0]        hop_limit,
  output mprf_pkg::mprf_res_t    echo
);
  import mprf_pkg::*;

  localparam int         IDX_W      = (ID_BYTES > 1) ? $clog2(ID_BYTES) : 1;
  localparam logic [7:0] POS_TOPIC  = 8'(ID_BYTES + MSG_ID_BYTES);
  localparam logic [7:0] POS_OFFSET = 8'(ID_BYTES + MSG_ID_BYTES + 1);
  localparam logic [7:0] POS_DATA   = 8'(ID_BYTES + MSG_ID_BYTES + 4);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ID_BYTES - 1);
  localparam logic [8:0] MAX_LEN    = 9'(MAX_PACKET_BYTES);

  logic [7:0]       pos_r,    pos_nxt;
  logic [7:0]       off_r,    off_nxt;
  logic [7:0]       topic_r,  topic_nxt;
  logic [5:0]       hop_r,    hop_nxt;
  logic [IDX_W-1:0] idx_r,    idx_nxt;
  logic             match_r,  match_nxt;
  logic             seen_r,   seen_nxt;

  logic [7:0] own_bytes [ID_BYTES];
  logic       in_path;
  logic       match_cur;
  logic [8:0] pkt_len;
  logic       malformed;
  logic [2:0] verdict;

  always_comb begin
    for (int k = 0; k < ID_BYTES; k++) begin
      own_bytes[k] = own_id[8*(ID_BYTES-1-k) +: 8];
    end
  end

  always_comb begin
    topic_nxt = (pos_r == POS_TOPIC)  ? data_byte : topic_r;
    off_nxt   = (pos_r == POS_OFFSET) ? data_byte : off_r;
    in_path   = (pos_r > POS_OFFSET) && (pos_r >= off_r);
    match_cur = match_r & (data_byte == own_bytes[idx_r]);

    hop_nxt   = hop_r;
    idx_nxt   = idx_r;
    match_nxt = match_r;
    seen_nxt  = seen_r;
    if (in_path) begin
      if (idx_r == LAST_IDX) begin
        seen_nxt  = seen_r | match_cur;
        hop_nxt   = (hop_r == 6'h3F) ? hop_r : hop_r + 6'd1;
        idx_nxt   = '0;
        match_nxt = 1'b1;
      end else begin
        idx_nxt   = idx_r + IDX_W'(1);
        match_nxt = match_cur;
      end
    end
    pos_nxt = (pos_r == 8'hFF) ? pos_r : pos_r + 8'd1;

    // Path length modulo entry size is the entry index left after the
    // last path byte, valid whenever the offset itself is in range.
    pkt_len   = {1'b0, pos_r} + 9'd1;
    malformed = (pos_r == 8'hFF) || (pkt_len > MAX_LEN) || (off_nxt < POS_DATA) ||
                ({1'b0, off_nxt} > pkt_len) || (idx_nxt != '0);

    priority if (malformed)                      verdict = VERD_MALFORMED;
    else if (hop_nxt >= {1'b0, hop_limit})       verdict = VERD_HOP_LIMIT;
    else if (seen_nxt)                           verdict = VERD_SEEN;
    else                                         verdict = VERD_RELAY;

    echo.out_byte    = data_byte;
    echo.is_appended = 1'b0;
    echo.topic_seen  = topic_nxt;
    echo.verdict     = last_byte ? verdict : VERD_PENDING;
    echo.end_of_run  = last_byte && (verdict != VERD_RELAY);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      off_r   <= '0;
      topic_r <= '0;
      hop_r   <= '0;
      idx_r   <= '0;
      match_r <= 1'b1;
      seen_r  <= 1'b0;
    end else if (in_fire) begin
      if (last_byte) begin
        pos_r   <= '0;
        off_r   <= '0;
        topic_r <= '0;
        hop_r   <= '0;
        idx_r   <= '0;
        match_r <= 1'b1;
        seen_r  <= 1'b0;
      end else begin
        pos_r   <= pos_nxt;
        off_r   <= off_nxt;
        topic_r <= topic_nxt;
        hop_r   <= hop_nxt;
        idx_r   <= idx_nxt;
        match_r <= match_nxt;
        seen_r  <= seen_nxt;
      end
    end
  end

endmodule : mprf_parse
`default_nettype wire

@@ hdl/mprf_out.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// mprf_out
// Result register and own-id append sequencer.
// ---------------------------------------------------------------------------
module mprf_out #(
  parameter int ID_BYTES = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_fire,
  input  wire mprf_pkg::mprf_res_t  echo,
  input  wire logic [63:0]          own_id,
  input  wire logic                 out_ready,
  output logic                      in_ready,
  output logic                      out_valid,
  output mprf_pkg::mprf_res_t       out_word
);
  import mprf_pkg::*;

  localparam int IDX_W = (ID_BYTES > 1) ? $clog2(ID_BYTES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ID_BYTES - 1);

  mprf_res_t        out_r;
  logic             out_valid_r;
  logic             app_act_r;
  logic [IDX_W-1:0] app_idx_r;
  logic             load_free;
  logic [7:0]       own_bytes [ID_BYTES];
  mprf_res_t        app_word;

  always_comb begin
    for (int k = 0; k < ID_BYTES; k++) begin
      own_bytes[k] = own_id[8*(ID_BYTES-1-k) +: 8];
    end
  end

  assign load_free = !out_valid_r || out_ready;
  assign in_ready  = load_free && !app_act_r;

  always_comb begin
    app_word.out_byte    = own_bytes[app_idx_r];
    app_word.is_appended = 1'b1;
    app_word.end_of_run  = (app_idx_r == LAST_IDX);
    app_word.verdict     = VERD_RELAY;
    app_word.topic_seen  = out_r.topic_seen;
  end

  // Hold the echo, then on a relay verdict walk the own id one word per free slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      app_act_r   <= 1'b0;
      app_idx_r   <= '0;
    end else if (in_fire) begin
      out_r       <= echo;
      out_valid_r <= 1'b1;
      app_act_r   <= (echo.verdict == VERD_RELAY);
      app_idx_r   <= '0;
    end else if (app_act_r && load_free) begin
      out_r       <= app_word;
      out_valid_r <= 1'b1;
      if (app_idx_r == LAST_IDX) begin
        app_act_r <= 1'b0;
      end else begin
        app_idx_r <= app_idx_r + IDX_W'(1);
      end
    end else if (out_valid_r && out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule : mprf_out
`default_nettype wire

@@ hdl/mesh_packet_relay_filter_core.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// mesh_packet_relay_filter_core
// Echoes a mesh packet byte by byte, checks its path and appends own id.
// ---------------------------------------------------------------------------
//  Port group  | Role   | Word
//  ------------+--------+-------------------------------------------------
//  in_ch       | sink   | data_byte[7:0], last_byte
//  out_ch      | source | out_byte[7:0], is_appended, end_of_run,
//              |        | verdict[2:0], topic_seen[7:0]
//  APB         | slave  | own_id at 0x0 (64 bit), hop_limit at 0x8 (5 bit)
//
//  One packet byte is accepted per cycle while in_ch.ready is high; its echo
//  word sits in the result register on the next cycle.
//  On a relayed last byte the output register emits ID_BYTES appended words,
//  and in_ch.ready stays low until the last of them has been loaded.
//  Output back-pressure stalls input only when the result register is full
//  and not being drained.
//  Reset is synchronous, active low; parse state and the output register
//  empty, and the registers return to own_id 0 and hop_limit 6.
// ---------------------------------------------------------------------------
module mesh_packet_relay_filter_core #(
  parameter int ID_BYTES         = 8,
  parameter int MSG_ID_BYTES     = 4,
  parameter int MAX_PACKET_BYTES = 255
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  mprf_in_if.sink                          in_ch,
  mprf_out_if.source                       out_ch,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mprf_pkg::CFG_AW-1:0] paddr,
  input  wire logic [mprf_pkg::CFG_DW-1:0] pwdata,
  output logic      [mprf_pkg::CFG_DW-1:0] prdata,
  output logic                             pready
);
  import mprf_pkg::*;

  logic [63:0] own_id;
  logic [4:0]  hop_limit;
  logic        in_ready;
  logic        in_fire;
  logic        out_valid;
  mprf_res_t   echo;
  mprf_res_t   out_word;

  // Advance parse state only on an accepted word
  assign in_fire = in_ch.valid && in_ready;

  mprf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .own_id    (own_id),
    .hop_limit (hop_limit)
  );

  // Header capture, entry compare and verdict for the current byte
  mprf_parse #(
    .ID_BYTES         (ID_BYTES),
    .MSG_ID_BYTES     (MSG_ID_BYTES),
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .data_byte (in_ch.data_byte),
    .last_byte (in_ch.last_byte),
    .own_id    (own_id),
    .hop_limit (hop_limit),
    .echo      (echo)
  );

  // Result register plus own-id append
  mprf_out #(
    .ID_BYTES (ID_BYTES)
  ) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .echo      (echo),
    .own_id    (own_id),
    .out_ready (out_ch.ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid;
  assign out_ch.out_byte    = out_word.out_byte;
  assign out_ch.is_appended = out_word.is_appended;
  assign out_ch.end_of_run  = out_word.end_of_run;
  assign out_ch.verdict     = out_word.verdict;
  assign out_ch.topic_seen  = out_word.topic_seen;

endmodule : mesh_packet_relay_filter_core
`default_nettype wire

@@ hdl/mprf_checker.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// mprf_checker
// Port-level checks on the relay filter's result stream.
// ---------------------------------------------------------------------------
module mprf_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       is_appended,
  input wire logic       end_of_run,
  input wire logic [2:0] verdict
);
  import mprf_pkg::*;

  // A stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // Appended words only follow a relay verdict
  a_app_relay: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_appended |-> verdict == VERD_RELAY)
    else $error("appended word without relay verdict");

  // A word that does not end its run is pending or part of a relay
  a_mid_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !end_of_run |-> verdict == VERD_PENDING || verdict == VERD_RELAY)
    else $error("final verdict on a word that does not end the run");

  // Input is held off while the own id is still being appended
  a_append_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && verdict == VERD_RELAY && !end_of_run |-> !in_ready)
    else $error("input taken during own id append");

endmodule : mprf_checker

bind mesh_packet_relay_filter_core mprf_checker u_mprf_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .is_appended (out_ch.is_appended),
  .end_of_run  (out_ch.end_of_run),
  .verdict     (out_ch.verdict)
);
`default_nettype wire
